>>> sv/fcfb_pkg.sv
// Shared constants, types and colour quantizer of the four-color framebuffer pixel writer.
package fcfb_pkg;

  // Panel limits and the packed store that follows from them.
  localparam int unsigned MaxWidth   = 512;
  localparam int unsigned MaxHeight  = 512;
  localparam int unsigned StoreBytes = (MaxWidth * MaxHeight + 3) / 4;
  localparam int unsigned AddrW      = $clog2(StoreBytes);
  localparam int unsigned ClrCntW    = $clog2(StoreBytes + 1);

  // Field widths of the stream and configuration ports.
  localparam int unsigned DimW      = 10;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned ReadAddrW = 16;
  localparam int unsigned ColorW    = 8;
  localparam int unsigned XW        = $clog2(MaxWidth);
  localparam int unsigned YW        = $clog2(MaxHeight);
  localparam int unsigned PixIdxW   = YW + DimW;
  localparam int unsigned InDataW   = 72;
  localparam int unsigned OutDataW  = 56;
  localparam int unsigned CfgIdxW   = 1;

  // Colour thresholds and 2-bit pixel codes.
  localparam logic [ColorW-1:0] ThrHigh = 8'd200;
  localparam logic [ColorW-1:0] ThrLow  = 8'd100;
  localparam logic [1:0] CodeBlack  = 2'b00;
  localparam logic [1:0] CodeWhite  = 2'b01;
  localparam logic [1:0] CodeRed    = 2'b10;
  localparam logic [1:0] CodeYellow = 2'b11;

  // Command codes carried in the input tuser.
  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PANEL_WIDTH  = 1'b0,
    REG_PANEL_HEIGHT = 1'b1
  } cfg_reg_e;

  // One access to the pixel store: a read and a write port.
  typedef struct packed {
    logic             re;
    logic [AddrW-1:0] raddr;
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
  } store_req_t;

  // Dirty box update request.
  typedef struct packed {
    logic          draw;
    logic          clear;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } box_upd_t;

  // Dirty bounding box.
  typedef struct packed {
    logic [DimW-1:0] x_min;
    logic [DimW-1:0] x_end;
    logic [DimW-1:0] y_min;
    logic [DimW-1:0] y_end;
  } box_t;

  // Quantizes an RGB colour to a 2-bit code; white wins over yellow over red.
  function automatic logic [1:0] colour_code(input logic [ColorW-1:0] r,
                                             input logic [ColorW-1:0] g,
                                             input logic [ColorW-1:0] b);
    logic [1:0] code;
    code = CodeBlack;
    if (r > ThrHigh && g > ThrHigh && b > ThrHigh) begin
      code = CodeWhite;
    end else if (r > ThrHigh && g > ThrHigh && b < ThrLow) begin
      code = CodeYellow;
    end else if (r > ThrHigh && g < ThrLow && b < ThrLow) begin
      code = CodeRed;
    end
    return code;
  endfunction

endpackage

>>> sv/fcfb_store.sv
// Packed pixel byte store: synchronous memory with a clearing pass after reset.
module fcfb_store (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fcfb_pkg::store_req_t    req_i,
  output logic [7:0]              rdata_o,
  output logic                    busy_o
);
  import fcfb_pkg::*;

  logic [7:0]         mem [StoreBytes];
  logic [7:0]         rdata_q;
  logic [ClrCntW-1:0] clr_cnt_q, clr_cnt_d;
  logic               clearing;
  logic               wr_en;
  logic [AddrW-1:0]   wr_addr;
  logic [7:0]         wr_data;

  // The clearing pass owns the write port until every byte is zero.
  assign clearing = clr_cnt_q < ClrCntW'(StoreBytes);
  assign clr_cnt_d = clearing ? clr_cnt_q + 1'b1 : clr_cnt_q;
  assign wr_en   = clearing | req_i.we;
  assign wr_addr = clearing ? clr_cnt_q[AddrW-1:0] : req_i.waddr;
  assign wr_data = clearing ? 8'h00 : req_i.wdata;

  // Clear sweep counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Memory array with one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clearing;

endmodule

>>> sv/fcfb_box.sv
// Dirty bounding box tracker for accepted pixel draws.
module fcfb_box (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fcfb_pkg::box_upd_t upd_i,
  output fcfb_pkg::box_t     box_next_o
);
  import fcfb_pkg::*;

  localparam box_t BoxEmpty = '{
    x_min: DimW'(MaxWidth),
    x_end: '0,
    y_min: DimW'(MaxHeight),
    y_end: '0
  };

  box_t            box_q, box_d;
  logic [DimW-1:0] ux, uy;

  assign ux = DimW'(upd_i.x);
  assign uy = DimW'(upd_i.y);

  // Clear empties the box; a draw widens it to cover the pixel.
  always_comb begin
    box_d = box_q;
    if (upd_i.clear) begin
      box_d = BoxEmpty;
    end else if (upd_i.draw) begin
      if (ux < box_q.x_min) box_d.x_min = ux;
      if (ux >= box_q.x_end) box_d.x_end = ux + 1'b1;
      if (uy < box_q.y_min) box_d.y_min = uy;
      if (uy >= box_q.y_end) box_d.y_end = uy + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= BoxEmpty;
    end else begin
      box_q <= box_d;
    end
  end

  assign box_next_o = box_d;

endmodule

>>> sv/four_color_framebuffer_pixel_writer.sv
// Top level of the four-color framebuffer pixel writer with its command sequencer.
//
// Each transaction on the input stream is one command: draw a pixel, read one packed byte, or
// clear the dirty box. A draw quantizes the colour to a 2-bit code and read-modify-writes the
// slot at x + y * width in a byte store holding four pixels per byte, lowest index in the lowest
// bits; draws outside the panel are dropped with accepted 0. Every command gives one result with
// the dirty box as it stands after the command. An item passes through accept, address
// calculation with the store read, then modify and write back, an order set by the
// read-modify-write through the single store, and one item is in work at a time; the output
// register lets the next item enter while a result waits. After reset the store is swept to
// zero, during which no item is accepted. Configuration writes are taken at any time and must
// only be issued while the block is idle.
module four_color_framebuffer_pixel_writer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fcfb_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fcfb_pkg::DimW-1:0]         cfg_data_i,
  // Command stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: pos_x[15:0], pos_y[31:16], red[39:32], green[47:40], blue[55:48], read_addr[71:56]
  input  logic [fcfb_pkg::InDataW-1:0]      s_axis_tdata_i,
  // tuser: cmd[1:0]
  input  logic [1:0]                        s_axis_tuser_i,
  // Result stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: accepted[0], read_byte[8:1], dirty_x_min[18:9], dirty_x_end[28:19],
  //        dirty_y_min[38:29], dirty_y_end[48:39], zero[55:49]
  output logic [fcfb_pkg::OutDataW-1:0]     m_axis_tdata_o
);
  import fcfb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOD
  } state_e;

  state_e                state_q;
  logic [DimW-1:0]       panel_width_q, panel_height_q;

  // Registered command.
  cmd_e                  cmd_q;
  logic [CoordW-1:0]     pos_x_q, pos_y_q;
  logic [ColorW-1:0]     red_q, green_q, blue_q;
  logic [ReadAddrW-1:0]  read_addr_q;

  // Results of the address stage.
  logic                  hit_q, byte_ok_q, rd_ok_q;
  logic [1:0]            slot_q, code_q;
  logic [XW-1:0]         ux_q;
  logic [YW-1:0]         uy_q;

  logic                  m_tvalid_q;
  logic [OutDataW-1:0]   m_tdata_q;

  logic [DimW-1:0]       w_eff, h_eff;
  logic                  in_panel, byte_ok, rd_ok;
  logic [PixIdxW-1:0]    pix_idx;
  logic [XW-1:0]         ux;
  logic [YW-1:0]         uy;
  logic                  out_free, commit, accept;
  logic [7:0]            rdata, wbyte, read_byte;
  logic                  store_busy;
  store_req_t            st_req;
  box_upd_t              box_upd;
  box_t                  box_next;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_width_q  <= DimW'(400);
      panel_height_q <= DimW'(300);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PANEL_WIDTH:  panel_width_q  <= cfg_data_i;
        REG_PANEL_HEIGHT: panel_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Address stage: clip to the panel and form the linear pixel index.
  assign w_eff = (panel_width_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : panel_width_q;
  assign h_eff = (panel_height_q > DimW'(MaxHeight)) ? DimW'(MaxHeight) : panel_height_q;
  assign in_panel = !pos_x_q[CoordW-1] && !pos_y_q[CoordW-1] &&
                    (pos_x_q < CoordW'(w_eff)) && (pos_y_q < CoordW'(h_eff));
  assign ux = pos_x_q[XW-1:0];
  assign uy = pos_y_q[YW-1:0];
  assign pix_idx = PixIdxW'(ux) + PixIdxW'(uy) * PixIdxW'(w_eff);
  assign byte_ok = (pix_idx >> 2) < PixIdxW'(StoreBytes);
  assign rd_ok   = (AddrW + 1)'(read_addr_q) < (AddrW + 1)'(StoreBytes);

  // Handshakes.
  assign out_free        = !m_tvalid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && !store_busy;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign commit          = (state_q == ST_MOD) && out_free;

  // Modify stage: replace the 2-bit slot in the byte read back.
  always_comb begin
    wbyte = rdata;
    case (slot_q)
      2'd0:    wbyte[1:0] = code_q;
      2'd1:    wbyte[3:2] = code_q;
      2'd2:    wbyte[5:4] = code_q;
      default: wbyte[7:6] = code_q;
    endcase
  end

  assign read_byte = (cmd_q == CMD_READ && rd_ok_q) ? rdata : 8'h00;

  // Store accesses: read in the address stage, write back at commit.
  always_comb begin
    st_req.re    = (state_q == ST_EXEC);
    st_req.raddr = (cmd_q == CMD_READ) ? read_addr_q[AddrW-1:0] : pix_idx[AddrW+1:2];
    st_req.we    = commit && (cmd_q == CMD_DRAW) && hit_q && byte_ok_q;
    st_req.waddr = st_req.raddr;
    st_req.wdata = wbyte;
  end

  // The address of the item in work is held, so the write goes back to the byte read.
  fcfb_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (st_req),
    .rdata_o (rdata),
    .busy_o  (store_busy)
  );

  // Box update at commit.
  always_comb begin
    box_upd.draw  = commit && (cmd_q == CMD_DRAW) && hit_q;
    box_upd.clear = commit && (cmd_q == CMD_CLEAR);
    box_upd.x     = ux_q;
    box_upd.y     = uy_q;
  end

  fcfb_box u_box (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (box_upd),
    .box_next_o (box_next)
  );

  // Sequencer, item registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      m_tvalid_q  <= 1'b0;
      m_tdata_q   <= '0;
      cmd_q       <= CMD_DRAW;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
      read_addr_q <= '0;
      hit_q       <= 1'b0;
      byte_ok_q   <= 1'b0;
      rd_ok_q     <= 1'b0;
      slot_q      <= '0;
      code_q      <= '0;
      ux_q        <= '0;
      uy_q        <= '0;
    end else begin
      // The output register empties when taken, unless a new result replaces it.
      if (m_axis_tready_i && !commit) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q       <= cmd_e'(s_axis_tuser_i);
            pos_x_q     <= s_axis_tdata_i[15:0];
            pos_y_q     <= s_axis_tdata_i[31:16];
            red_q       <= s_axis_tdata_i[39:32];
            green_q     <= s_axis_tdata_i[47:40];
            blue_q      <= s_axis_tdata_i[55:48];
            read_addr_q <= s_axis_tdata_i[71:56];
            state_q     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          hit_q     <= in_panel;
          byte_ok_q <= byte_ok;
          rd_ok_q   <= rd_ok;
          slot_q    <= pix_idx[1:0];
          code_q    <= colour_code(red_q, green_q, blue_q);
          ux_q      <= ux;
          uy_q      <= uy;
          state_q   <= ST_MOD;
        end
        ST_MOD: begin
          // Wait here, store data held, until the output register is free.
          if (out_free) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= {7'b0, box_next.y_end, box_next.y_min, box_next.x_end,
                           box_next.x_min, read_byte, (cmd_q == CMD_DRAW) && hit_q};
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

  // No command enters while the store is still being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !store_busy)
    else $error("command accepted during store clearing pass");

  // A store write happens only when the item leaves the modify stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_req.we |-> (state_q == ST_MOD) && out_free)
    else $error("store write outside the commit cycle");

  // A new result appears only after a commit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> $past(state_q == ST_MOD))
    else $error("result produced without a committed item");

  // An accepted draw always leaves a non-empty dirty box.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && m_tdata_q[0]) |->
      (m_tdata_q[18:9] < m_tdata_q[28:19]) && (m_tdata_q[38:29] < m_tdata_q[48:39]))
    else $error("accepted draw reported with an empty dirty box");

endmodule

>>> verif/four_color_framebuffer_pixel_writer_tb.sv
// Self-checking testbench of the four-color framebuffer pixel writer against a shadow frame store.
module four_color_framebuffer_pixel_writer_tb;
  import fcfb_pkg::*;

  // The command code that has no function in the block.
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int CycleLimit = 400000;
  localparam int ShownMismatches = 10;

  // Command transaction payload, first field in the lowest bits.
  typedef struct packed {
    logic [ReadAddrW-1:0] read_addr;
    logic [ColorW-1:0]    blue;
    logic [ColorW-1:0]    green;
    logic [ColorW-1:0]    red;
    logic [CoordW-1:0]    pos_y;
    logic [CoordW-1:0]    pos_x;
  } pixel_cmd_t;

  // Result transaction payload, first field in the lowest bits.
  typedef struct packed {
    logic [6:0]      pad;
    logic [DimW-1:0] y_end;
    logic [DimW-1:0] y_min;
    logic [DimW-1:0] x_end;
    logic [DimW-1:0] x_min;
    logic [7:0]      read_byte;
    logic            accepted;
  } pixel_result_t;

  // One row of the directed table; typed rows carry a hand-written result.
  typedef struct packed {
    logic [1:0]    op;
    pixel_cmd_t    data;
    logic          typed;
    pixel_result_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [DimW-1:0]      cfg_data = '0;
  logic                 cmd_tvalid = 1'b0;
  logic                 cmd_tready;
  pixel_cmd_t           cmd_tdata = '0;
  logic [1:0]           cmd_tuser = '0;
  logic                 res_tvalid;
  logic                 res_tready = 1'b0;
  logic [OutDataW-1:0]  res_tdata;

  // Shadow copy of the block state and its panel registers.
  logic [7:0] shadow_frame [StoreBytes];
  int panel_w, panel_h;
  int box_x_min, box_x_end, box_y_min, box_y_end;

  pixel_result_t pending_results[$];
  dir_row_t      directed_rows[$];

  int   cycle_count = 0;
  int   sent_count = 0;
  int   received = 0;
  int   mismatches = 0;
  int   pixels_written = 0;
  int   bytes_read = 0;
  int   box_clears = 0;
  logic hold_sink = 1'b0;

  always #2 clk = ~clk;

  four_color_framebuffer_pixel_writer uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (cmd_tvalid),
    .s_axis_tready_o (cmd_tready),
    .s_axis_tdata_i  (cmd_tdata),
    .s_axis_tuser_i  (cmd_tuser),
    .m_axis_tvalid_o (res_tvalid),
    .m_axis_tready_i (res_tready),
    .m_axis_tdata_o  (res_tdata)
  );

  // Maps a colour to its 2-bit code; the tests go white, yellow, red, else black.
  function automatic logic [1:0] quantize_colour(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic r_hi, g_hi, b_hi, g_lo, b_lo;
    r_hi = r > ThrHigh;
    g_hi = g > ThrHigh;
    b_hi = b > ThrHigh;
    g_lo = g < ThrLow;
    b_lo = b < ThrLow;
    if (r_hi && g_hi && b_hi) return CodeWhite;
    if (r_hi && g_hi && b_lo) return CodeYellow;
    if (r_hi && g_lo && b_lo) return CodeRed;
    return CodeBlack;
  endfunction

  function automatic void empty_box();
    box_x_min = MaxWidth;
    box_x_end = 0;
    box_y_min = MaxHeight;
    box_y_end = 0;
  endfunction

  // Applies one command to the shadow state and returns the result it must give.
  function automatic pixel_result_t apply_command(logic [1:0] op, pixel_cmd_t c);
    pixel_result_t r;
    int px, py, w_eff, h_eff, idx;
    r = '0;
    w_eff = (panel_w > MaxWidth) ? MaxWidth : panel_w;
    h_eff = (panel_h > MaxHeight) ? MaxHeight : panel_h;
    case (op)
      CMD_DRAW: begin
        px = $signed(c.pos_x);
        py = $signed(c.pos_y);
        if (px >= 0 && py >= 0 && px < w_eff && py < h_eff) begin
          idx = px + py * w_eff;
          shadow_frame[idx / 4][(idx % 4) * 2 +: 2] = quantize_colour(c.red, c.green, c.blue);
          if (px < box_x_min) box_x_min = px;
          if (px >= box_x_end) box_x_end = px + 1;
          if (py < box_y_min) box_y_min = py;
          if (py >= box_y_end) box_y_end = py + 1;
          r.accepted = 1'b1;
          pixels_written++;
        end
      end
      CMD_READ: begin
        r.read_byte = shadow_frame[c.read_addr];
        bytes_read++;
      end
      CMD_CLEAR: begin
        empty_box();
        box_clears++;
      end
      // The unused command leaves everything as it is.
      default: ;
    endcase
    r.x_min = DimW'(box_x_min);
    r.x_end = DimW'(box_x_end);
    r.y_min = DimW'(box_y_min);
    r.y_end = DimW'(box_y_end);
    return r;
  endfunction

  function automatic pixel_result_t outcome(int acc, int rb, int xmin, int xend, int ymin,
                                            int yend);
    pixel_result_t r;
    r = '0;
    r.accepted  = acc[0];
    r.read_byte = rb[7:0];
    r.x_min     = DimW'(xmin);
    r.x_end     = DimW'(xend);
    r.y_min     = DimW'(ymin);
    r.y_end     = DimW'(yend);
    return r;
  endfunction

  function automatic void add_row(logic [1:0] op, int x, int y, int r, int g, int b, int addr,
                                  logic typed, pixel_result_t want);
    dir_row_t row;
    row.op             = op;
    row.data.pos_x     = CoordW'(x);
    row.data.pos_y     = CoordW'(y);
    row.data.red       = ColorW'(r);
    row.data.green     = ColorW'(g);
    row.data.blue      = ColorW'(b);
    row.data.read_addr = ReadAddrW'(addr);
    row.typed          = typed;
    row.want           = want;
    directed_rows.push_back(row);
  endfunction

  // Colour level biased toward the quantizer thresholds.
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 99));
      1:       return 8'($urandom_range(201, 255));
      2:       return $urandom_range(0, 1) ? ThrLow : ThrHigh;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offers one command and records its expected result once the transaction is taken.
  task automatic send_item(logic [1:0] op, pixel_cmd_t c, logic typed, pixel_result_t want);
    int gap;
    pixel_result_t predicted;
    // Every other run of 32 commands goes without gaps.
    gap = sent_count[5] ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      cmd_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_tvalid <= 1'b1;
    cmd_tdata  <= c;
    cmd_tuser  <= op;
    do @(posedge clk); while (!cmd_tready);
    predicted = apply_command(op, c);
    pending_results.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_idle();
    cmd_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_panel_reg(cfg_reg_e idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[DimW-1:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PANEL_WIDTH) begin
      panel_w = val % 1024;
    end else begin
      panel_h = val % 1024;
    end
  endtask

  // Random commands, mostly draws and reads that land inside the current panel.
  task automatic run_random(int count);
    pixel_cmd_t c;
    logic [1:0] op;
    int sel, w_eff, h_eff, span;
    w_eff = (panel_w > MaxWidth) ? MaxWidth : panel_w;
    h_eff = (panel_h > MaxHeight) ? MaxHeight : panel_h;
    span = (w_eff * h_eff + 3) / 4;
    repeat (count) begin
      c.pos_x     = 16'($urandom);
      c.pos_y     = 16'($urandom);
      c.red       = pick_level();
      c.green     = pick_level();
      c.blue      = pick_level();
      c.read_addr = 16'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        op = CMD_DRAW;
        if (w_eff > 0 && h_eff > 0 && $urandom_range(0, 4) != 0) begin
          c.pos_x = 16'($urandom_range(0, w_eff - 1));
          c.pos_y = 16'($urandom_range(0, h_eff - 1));
        end else if ($urandom_range(0, 1) == 0) begin
          // Just past the right edge, or one column left of the origin.
          c.pos_x = 16'(($urandom_range(0, 1) == 0) ? w_eff : -1);
          c.pos_y = 16'($urandom_range(0, h_eff));
        end
      end else if (sel < 85) begin
        op = CMD_READ;
        if (span > 0 && $urandom_range(0, 3) != 0) c.read_addr = 16'($urandom_range(0, span - 1));
      end else if (sel < 93) begin
        op = CMD_CLEAR;
      end else begin
        op = CmdUnused;
      end
      send_item(op, c, 1'b0, '0);
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= ShownMismatches) begin
        $display("result %0d: %s expected %0d, got %0d", received, name, want, got);
      end
    end
  endtask

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_results.size());
      $display("** four_color_framebuffer_pixel_writer: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request, compare with the oldest entry.
  initial begin : result_sink
    pixel_result_t got, want;
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = received[5] ? 0 : $urandom_range(0, 18);
      if (hold_sink) begin
        hold_sink = 1'b0;
        gap = 250;
      end
      if (gap > 0) begin
        res_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_tready <= 1'b1;
      do @(posedge clk); while (!res_tvalid);
      got = res_tdata;
      received++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownMismatches) begin
          $display("result %0d arrived with nothing expected: %h", received, got);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", want.accepted, got.accepted);
        check_field("read_byte", want.read_byte, got.read_byte);
        check_field("dirty_x_min", want.x_min, got.x_min);
        check_field("dirty_x_end", want.x_end, got.x_end);
        check_field("dirty_y_min", want.y_min, got.y_min);
        check_field("dirty_y_end", want.y_end, got.y_end);
        check_field("padding", 0, got.pad);
      end
    end
  end

  // Command side: directed table, then random phases over several panel sizes.
  initial begin : stimulus
    int phase_w [8] = '{1, 1023, 0, 512, 7, 4, 513, 13};
    int phase_h [8] = '{1, 1023, 5, 512, 3, 1, 0, 9};
    int phase_n [8] = '{40, 80, 30, 60, 80, 60, 30, 110};
    foreach (shadow_frame[i]) shadow_frame[i] = '0;
    empty_box();
    panel_w = 400;
    panel_h = 300;

    // Panel at its reset size of 400 by 300.
    add_row(CMD_DRAW, 0, 0, 255, 255, 255, 0, 1'b1, outcome(1, 0, 0, 1, 0, 1));
    add_row(CMD_READ, 0, 0, 0, 0, 0, 0, 1'b1, outcome(0, 8'h01, 0, 1, 0, 1));
    add_row(CMD_DRAW, 399, 299, 201, 201, 99, 0, 1'b1, outcome(1, 0, 0, 400, 0, 300));
    add_row(CMD_READ, 0, 0, 0, 0, 0, 29999, 1'b1, outcome(0, 8'hC0, 0, 400, 0, 300));
    // Coordinates outside the panel are dropped.
    add_row(CMD_DRAW, 400, 0, 255, 255, 255, 0, 1'b1, outcome(0, 0, 0, 400, 0, 300));
    add_row(CMD_DRAW, 0, 300, 255, 255, 255, 0, 1'b1, outcome(0, 0, 0, 400, 0, 300));
    add_row(CMD_DRAW, -1, 0, 255, 255, 255, 0, 1'b1, outcome(0, 0, 0, 400, 0, 300));
    add_row(CMD_DRAW, -32768, 32767, 255, 0, 0, 0, 1'b1, outcome(0, 0, 0, 400, 0, 300));
    add_row(CMD_DRAW, 32767, -32768, 255, 0, 0, 0, 1'b1, outcome(0, 0, 0, 400, 0, 300));
    add_row(CMD_DRAW, 1, 0, 201, 99, 99, 0, 1'b1, outcome(1, 0, 0, 400, 0, 300));
    add_row(CMD_READ, 0, 0, 0, 0, 0, 0, 1'b1, outcome(0, 8'h09, 0, 400, 0, 300));
    // Colours right at the thresholds fall to black.
    add_row(CMD_DRAW, 2, 0, 200, 200, 200, 0, 1'b0, '0);
    add_row(CMD_DRAW, 3, 0, 201, 201, 100, 0, 1'b0, '0);
    add_row(CMD_DRAW, 2, 1, 201, 100, 99, 0, 1'b0, '0);
    add_row(CMD_DRAW, 3, 1, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_READ, 0, 0, 0, 0, 0, 65535, 1'b1, outcome(0, 0, 0, 400, 0, 300));
    add_row(CMD_READ, 0, 0, 0, 0, 0, 100, 1'b0, '0);
    // Clear empties the box but keeps the store; the unused command changes nothing.
    add_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 1'b1, outcome(0, 0, 512, 0, 512, 0));
    add_row(CmdUnused, -1, -1, 255, 255, 255, 65535, 1'b1, outcome(0, 0, 512, 0, 512, 0));
    add_row(CMD_READ, 0, 0, 0, 0, 0, 0, 1'b1, outcome(0, 8'h09, 512, 0, 512, 0));
    add_row(CMD_DRAW, 5, 7, 255, 255, 255, 0, 1'b1, outcome(1, 0, 5, 6, 7, 8));
    add_row(CMD_DRAW, 100, 2, 255, 255, 0, 0, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
                directed_rows[i].want);
    end
    run_random(60);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_panel_reg(REG_PANEL_WIDTH, phase_w[p]);
      write_panel_reg(REG_PANEL_HEIGHT, phase_h[p]);
      cfg_valid <= 1'b0;
      // The small panel phase also backs up the block behind a stalled result side.
      if (p == 4) hold_sink = 1'b1;
      run_random(phase_n[p]);
    end
    wait_idle();

    $display("Ran %0d commands on 9 panel sizes: %0d pixels written, %0d byte reads, %0d clears.",
             sent_count, pixels_written, bytes_read, box_clears);
    $display("Covered colour thresholds, off-panel and capped or zero sizes, same-byte updates.");
    if (mismatches == 0) begin
      $display("** four_color_framebuffer_pixel_writer: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** four_color_framebuffer_pixel_writer: FAILED **");
    end
    $finish;
  end

endmodule
